// ===== sv/sbb_pkg.sv =====
// shared types and constants for the separable box blur
package sbb_pkg;
  localparam int MaxWidth = 1024;
  localparam int MaxRadius = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_BLUR_RADIUS,
    REG_GREY_MODE
  } reg_idx_t;

  // item kinds on the input channel
  typedef enum logic {
    OP_PIXEL,
    OP_DRAIN
  } blur_op_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } pix_t;
endpackage

// ===== sv/sbb_ram.sv =====
// generic single port write, single port registered read ram
module sbb_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/sbb_lane.sv =====
// one channel lane: window accumulator and rounding divide
module sbb_lane (
  input  logic        clk,
  input  logic        clr,
  input  logic        acc_en,
  input  logic [7:0]  pix,
  input  logic        div_start,
  input  logic [7:0]  dvsr,
  input  logic        enable,
  output logic [7:0]  result
);
  // window sum up to 225*255, fits in 16 bits
  logic [15:0] sum_r;
  logic [16:0] rem_r;
  logic [16:0] quo_r;
  logic [4:0]  cnt_r;
  logic [16:0] trial;

  assign trial = {rem_r[15:0], quo_r[16]} - {9'd0, dvsr};

  always_ff @(posedge clk) begin
    if (clr) begin
      sum_r <= '0;
    end else if (acc_en) begin
      sum_r <= sum_r + {8'd0, pix};
    end
    if (div_start) begin
      // numerator includes the half divisor for round to nearest
      quo_r <= {1'b0, sum_r} + {10'd0, dvsr[7:1]};
      rem_r <= '0;
      cnt_r <= 5'd17;
    end else if (cnt_r != 5'd0) begin
      cnt_r <= cnt_r - 5'd1;
      if (!trial[16]) begin
        rem_r <= trial;
        quo_r <= {quo_r[15:0], 1'b1};
      end else begin
        rem_r <= {rem_r[15:0], quo_r[16]};
        quo_r <= {quo_r[15:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!enable) begin
      result = 8'd0;
    end else if (quo_r > 17'd255) begin
      result = 8'd255;
    end else begin
      result = quo_r[7:0];
    end
  end
endmodule

// ===== sv/separable_box_blur_clamped.sv =====
// top level of the streaming box blur with clamped borders
// Streaming box blur, 8-bit pixels in raster order, three channels or grey.
// Input channel in_valid/in_ready carries one item: a pixel (operation 0) or
// a drain tick (operation 1). Output channel out_valid/out_ready carries one
// blurred pixel; frame_done marks the last pixel of the frame.
// Output number k of a frame appears after input pixel k + r*W + r; once the
// last pixel is in, drain ticks flush the pending outputs one each.
// An item that produces an output walks the window from the row store one
// pixel a cycle, (2r+1)^2 reads through its single read port; the lanes then
// divide, and the result is loaded into the output register once it is
// free. Only then is the next item taken. An item without output is taken
// while the block stays idle. Three lanes accumulate the channels in
// parallel and share one sequencer; their results merge into the output
// register. Configuration is written with cfg_we/cfg_index/cfg_data only
// while idle, a rule for the user that the block does not enforce. A write
// restarts the frame and holds in_ready low for one cycle. Reset (rst_n low,
// synchronous) restores the default registers and positions and holds
// in_ready low in the cycle after; the row store is not cleared. When the
// receiver stalls the result is held in the output register; items without
// output are still taken, and the next result waits in the lanes.
module separable_box_blur_clamped #(
  parameter int MAX_WIDTH  = sbb_pkg::MaxWidth,
  parameter int MAX_RADIUS = sbb_pkg::MaxRadius
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_chan_a,
  input  logic [7:0]  in_chan_b,
  input  logic [7:0]  in_chan_c,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_blur_a,
  output logic [7:0]  out_blur_b,
  output logic [7:0]  out_blur_c,
  output logic        out_frame_done
);
  localparam int RingRows = 2 * MAX_RADIUS + 2;
  localparam int Depth = RingRows * MAX_WIDTH;
  localparam int AW = $clog2(Depth);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int SW = $clog2(RingRows);
  localparam int CW = XW + 1;

  // config registers
  logic [10:0] width_r;
  logic [15:0] height_r;
  logic [2:0]  radius_r;
  logic        grey_r;
  logic        cfg_busy_r;

  logic [CW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [2:0]    r_eff;
  always_comb begin
    if (width_r == 11'd0) begin
      w_eff = CW'(1);
    end else if ({21'd0, width_r} > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_r);
    end
    h_eff = (height_r == 16'd0) ? 16'd1 : height_r;
    r_eff = ({29'd0, radius_r} > 32'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius_r;
  end

  // positions; received and emitted counts kept alongside
  logic [CW-1:0] in_col_r, out_col_r;
  logic [15:0]   out_row_r;
  logic [SW-1:0] in_slot_r, out_slot_r;
  logic [31:0]   recv_r, emit_r;
  logic [31:0]   total_r, lag_r;

  sbb_pkg::state_t state_r, state_nxt;

  // window walk
  logic signed [4:0] dy_r, dx_r;
  logic [4:0]  dcnt_r;
  logic        acc_r;
  logic [7:0]  dvsr_r;
  logic [4:0]  side;
  assign side = {1'b0, r_eff, 1'b0} + 5'd1;

  // ram ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  sbb_pkg::pix_t wdata, rdata;

  sbb_ram #(.Width(24), .Depth(Depth)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic accept;
  assign in_ready = (state_r == sbb_pkg::ST_IDLE) && !cfg_busy_r;
  assign accept = in_valid && in_ready;

  logic pix_take, fire;
  logic in_full;
  assign in_full = recv_r >= total_r;
  assign pix_take = accept && (in_operation == sbb_pkg::OP_PIXEL) && !in_full;
  assign fire = accept && (emit_r < total_r) &&
                ((in_operation == sbb_pkg::OP_DRAIN) ? in_full :
                 (!in_full && (recv_r + 32'd1 >= emit_r + lag_r + 32'd1)));

  // output register free for the next result
  logic out_load;
  assign out_load = (state_r == sbb_pkg::ST_OUT) && (!out_valid || out_ready);

  assign we = pix_take;
  assign waddr = AW'({{(32-SW){1'b0}}, in_slot_r} * 32'(MAX_WIDTH) +
                     {{(32-CW){1'b0}}, in_col_r});
  assign wdata = '{a: in_chan_a, b: in_chan_b, c: in_chan_c};

  // clamped read address for the current window offset
  logic signed [17:0] yy;
  logic signed [CW+1:0] xx;
  logic [15:0] ry;
  logic [CW-1:0] rx;
  logic [SW-1:0] rslot;
  logic signed [6:0] sy;
  always_comb begin
    yy = $signed({2'b0, out_row_r}) + 18'(dy_r);
    xx = $signed({2'b0, out_col_r}) + (CW+2)'(dx_r);
    if (yy < 0) begin
      ry = 16'd0;
    end else if (yy > $signed({2'b0, h_eff - 16'd1})) begin
      ry = h_eff - 16'd1;
    end else begin
      ry = yy[15:0];
    end
    if (xx < 0) begin
      rx = '0;
    end else if (xx > $signed({2'b0, w_eff - CW'(1)})) begin
      rx = w_eff - CW'(1);
    end else begin
      rx = xx[CW-1:0];
    end
    // slot of ry relative to out_slot, within +-MAX_RADIUS rows
    sy = $signed({1'b0, out_slot_r}) + 7'($signed({1'b0, ry}) - $signed({1'b0, out_row_r}));
    if (sy < 0) begin
      rslot = SW'(sy + 7'(RingRows));
    end else if (sy >= 7'(RingRows)) begin
      rslot = SW'(sy - 7'(RingRows));
    end else begin
      rslot = SW'(sy);
    end
  end
  assign raddr = AW'({{(32-SW){1'b0}}, rslot} * 32'(MAX_WIDTH) +
                     {{(32-CW){1'b0}}, rx});

  logic lane_clr, div_start;
  logic [4:0] div_cnt_r;
  logic [7:0] res_a, res_b, res_c;

  assign lane_clr = fire;
  // the last window pixel is added during the first divide cycle
  assign div_start = (state_r == sbb_pkg::ST_DIV) && (div_cnt_r == 5'd1);

  sbb_lane u_lane_a (.clk(clk), .clr(lane_clr), .acc_en(acc_r), .pix(rdata.a),
    .div_start(div_start), .dvsr(dvsr_r), .enable(1'b1), .result(res_a));
  sbb_lane u_lane_b (.clk(clk), .clr(lane_clr), .acc_en(acc_r), .pix(rdata.b),
    .div_start(div_start), .dvsr(dvsr_r), .enable(!grey_r), .result(res_b));
  sbb_lane u_lane_c (.clk(clk), .clr(lane_clr), .acc_en(acc_r), .pix(rdata.c),
    .div_start(div_start), .dvsr(dvsr_r), .enable(!grey_r), .result(res_c));

  logic last_out;
  assign last_out = (out_row_r == h_eff - 16'd1) && (out_col_r == w_eff - CW'(1));

  logic walk_end;
  assign walk_end = (dcnt_r == side - 5'd1) && (dx_r == $signed({2'b0, r_eff}));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbb_pkg::ST_IDLE: if (fire) state_nxt = sbb_pkg::ST_SUM;
      sbb_pkg::ST_SUM:  if (walk_end) state_nxt = sbb_pkg::ST_DIV;
      sbb_pkg::ST_DIV:  if (div_cnt_r == 5'd19) state_nxt = sbb_pkg::ST_OUT;
      sbb_pkg::ST_OUT:  if (out_load) state_nxt = sbb_pkg::ST_IDLE;
      default:          state_nxt = sbb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbb_pkg::ST_IDLE;
      width_r <= 11'd1024;
      height_r <= 16'd1024;
      radius_r <= 3'd1;
      grey_r <= 1'b0;
      cfg_busy_r <= 1'b1;
      in_col_r <= '0; in_slot_r <= '0;
      out_col_r <= '0; out_row_r <= '0; out_slot_r <= '0;
      recv_r <= '0; emit_r <= '0;
      out_valid <= 1'b0;
      acc_r <= 1'b0;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      // totals are registered from the config registers; in_ready is low while they update
      cfg_busy_r <= cfg_we;
      total_r <= {16'd0, h_eff} * {{(32-CW){1'b0}}, w_eff};
      lag_r <= {29'd0, r_eff} * {{(32-CW){1'b0}}, w_eff} + {29'd0, r_eff};
      dvsr_r <= 8'({3'd0, side} * {3'd0, side});
      acc_r <= (state_r == sbb_pkg::ST_SUM);
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          sbb_pkg::REG_FRAME_WIDTH:  width_r <= cfg_data[10:0];
          sbb_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data;
          sbb_pkg::REG_BLUR_RADIUS:  radius_r <= cfg_data[2:0];
          sbb_pkg::REG_GREY_MODE:    grey_r <= cfg_data[0];
          default: ;
        endcase
        in_col_r <= '0; in_slot_r <= '0;
        out_col_r <= '0; out_row_r <= '0; out_slot_r <= '0;
        recv_r <= '0; emit_r <= '0;
      end else begin
        if (pix_take) begin
          recv_r <= recv_r + 32'd1;
          if (in_col_r + CW'(1) >= w_eff) begin
            in_col_r <= '0;
            in_slot_r <= (in_slot_r == SW'(RingRows - 1)) ? '0 : in_slot_r + SW'(1);
          end else begin
            in_col_r <= in_col_r + CW'(1);
          end
        end
        if (fire) begin
          dy_r <= -$signed({2'b0, r_eff});
          dx_r <= -$signed({2'b0, r_eff});
          dcnt_r <= '0;
        end
        if (state_r == sbb_pkg::ST_SUM) begin
          if (dx_r == $signed({2'b0, r_eff})) begin
            dx_r <= -$signed({2'b0, r_eff});
            dy_r <= dy_r + 5'sd1;
            dcnt_r <= dcnt_r + 5'd1;
          end else begin
            dx_r <= dx_r + 5'sd1;
          end
        end
        if (state_r == sbb_pkg::ST_DIV) begin
          div_cnt_r <= div_cnt_r + 5'd1;
        end else begin
          div_cnt_r <= '0;
        end
        if (out_load) begin
          out_valid <= 1'b1;
          out_blur_a <= res_a;
          out_blur_b <= res_b;
          out_blur_c <= res_c;
          out_frame_done <= last_out;
          if (last_out) begin
            in_col_r <= '0; in_slot_r <= '0;
            out_col_r <= '0; out_row_r <= '0; out_slot_r <= '0;
            recv_r <= '0; emit_r <= '0;
          end else begin
            emit_r <= emit_r + 32'd1;
            if (out_col_r + CW'(1) >= w_eff) begin
              out_col_r <= '0;
              out_row_r <= out_row_r + 16'd1;
              out_slot_r <= (out_slot_r == SW'(RingRows - 1)) ? '0 : out_slot_r + SW'(1);
            end else begin
              out_col_r <= out_col_r + CW'(1);
            end
          end
        end
      end
    end
  end

  // a waiting result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_blur_a, out_blur_b, out_blur_c, out_frame_done}))
    else $error("result changed while stalled");
  // result appears only after the divide phase
  a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == sbb_pkg::ST_OUT)
    else $error("result without divide");
  // emitted count never passes received count
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r <= recv_r) else $error("output ahead of input");
endmodule
